@@ sv/adcq_pkg.sv @@
// ----------------------------------------------------------------------------
// adcq_pkg
// Shared types and constants for the ADC/capacitor-id frame quality flagger.
// ----------------------------------------------------------------------------
`default_nettype none

package adcq_pkg;

  localparam int unsigned ADC_W        = 8;
  localparam int unsigned CAP_W        = 2;
  localparam int unsigned SOI_W        = 4;
  localparam int unsigned BX_W         = 12;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 8;

  localparam int unsigned BLOCK_LENGTH = 8;
  localparam int unsigned HALF_LENGTH  = BLOCK_LENGTH / 2;
  localparam int unsigned HALF_W       = (HALF_LENGTH > 1) ? $clog2(HALF_LENGTH) : 1;
  localparam int unsigned COUNT_MAX    = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STUCK_THRESHOLD    = 2'd0,
    REG_BLOCK_THRESHOLD    = 2'd1,
    REG_EXPECTED_CAP_PHASE = 2'd2
  } reg_index_e;

  typedef struct packed {
    logic [ADC_W-1:0] adc;
    logic [CAP_W-1:0] capid;
    logic [SOI_W-1:0] soi_index;
    logic [BX_W-1:0]  bunch_crossing;
    logic             last_sample;
  } sample_t;

  typedef struct packed {
    logic             stuck_adc;
    logic             repeated_block;
    logic             bad_cap_phase;
    logic             cap_not_rotating;
    logic [COUNT_W-1:0] frame_length;
  } result_t;

  typedef struct packed {
    logic [ADC_W-1:0] stuck_threshold;
    logic [ADC_W-1:0] block_threshold;
    logic [CAP_W-1:0] expected_cap_phase;
  } cfg_t;

endpackage

`default_nettype wire

@@ sv/adcq_in_reg.sv @@
// ----------------------------------------------------------------------------
// adcq_in_reg
// Input register: captures one sample beat and holds it until the frame
// evaluator consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module adcq_in_reg
  import adcq_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire sample_t in_sample_i,
  input  wire logic    advance_i,
  output logic         s1_valid_o,
  output sample_t      s1_sample_o
);

  logic    valid_q, valid_d;
  sample_t sample_q;
  logic    load;

  // The held beat leaves whenever the downstream side can take it, so a new
  // beat can enter in the same cycle.
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_q <= in_sample_i;
    end
  end

  assign s1_valid_o  = valid_q;
  assign s1_sample_o = sample_q;

endmodule

`default_nettype wire

@@ sv/adcq_frame_eval.sv @@
// ----------------------------------------------------------------------------
// adcq_frame_eval
// Running frame state and the flag logic evaluated on the last sample.
// ----------------------------------------------------------------------------
`default_nettype none

module adcq_frame_eval
  import adcq_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    consume_i,
  input  wire sample_t sample_i,
  input  wire cfg_t    cfg_i,
  output result_t      result_o
);

  logic [COUNT_W-1:0] count_q, count_d;
  logic [ADC_W-1:0]   first_code_q, first_code_d;
  logic               all_equal_q, all_equal_d;
  logic               halves_match_q, halves_match_d;
  logic               soi_above_q, soi_above_d;
  logic               soi_bad_q, soi_bad_d;
  logic               soi_reached_q, soi_reached_d;
  logic [CAP_W-1:0]   prev_capid_q;
  logic               rot_broken_q, rot_broken_d;
  logic [ADC_W-1:0]   half_mem [HALF_LENGTH];

  logic               is_first;
  logic               in_first_half;
  logic               in_second_half;
  logic               at_soi;
  logic [COUNT_W-1:0] rd_offset;
  logic [HALF_W-1:0]  rd_idx;
  logic [CAP_W-1:0]   phase;
  logic               multi;
  logic               stuck;

  assign is_first       = (count_q == '0);
  assign in_first_half  = (count_q < COUNT_W'(HALF_LENGTH));
  assign in_second_half = !in_first_half && (count_q < COUNT_W'(2 * HALF_LENGTH));
  assign at_soi         = (count_q == COUNT_W'(sample_i.soi_index));
  assign rd_offset      = count_q - COUNT_W'(HALF_LENGTH);
  assign rd_idx         = rd_offset[HALF_W-1:0];
  // Two-bit wrap gives the difference mod 4 directly.
  assign phase          = sample_i.capid - sample_i.bunch_crossing[CAP_W-1:0];

  always_comb begin
    first_code_d   = is_first ? sample_i.adc : first_code_q;
    all_equal_d    = is_first ? 1'b1 : (all_equal_q && (sample_i.adc == first_code_q));
    rot_broken_d   = rot_broken_q ||
                     (!is_first && (sample_i.capid != prev_capid_q + CAP_W'(1)));
    halves_match_d = halves_match_q &&
                     !(in_second_half && (half_mem[rd_idx] != sample_i.adc));
    soi_reached_d  = soi_reached_q || at_soi;
    soi_above_d    = at_soi ? (sample_i.adc > cfg_i.block_threshold) : soi_above_q;
    soi_bad_d      = at_soi ? (phase != cfg_i.expected_cap_phase) : soi_bad_q;
    count_d        = (count_q < COUNT_W'(COUNT_MAX)) ? count_q + COUNT_W'(1) : count_q;
  end

  assign multi = (count_d >= COUNT_W'(2));
  assign stuck = multi && all_equal_d && (first_code_d >= cfg_i.stuck_threshold);

  always_comb begin
    result_o.stuck_adc        = stuck;
    result_o.repeated_block   = !stuck && (count_d == COUNT_W'(BLOCK_LENGTH)) &&
                                soi_reached_d && soi_above_d && halves_match_d;
    result_o.bad_cap_phase    = soi_reached_d && soi_bad_d;
    result_o.cap_not_rotating = multi && rot_broken_d;
    result_o.frame_length     = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      first_code_q   <= '0;
      all_equal_q    <= 1'b1;
      halves_match_q <= 1'b1;
      soi_above_q    <= 1'b0;
      soi_bad_q      <= 1'b0;
      soi_reached_q  <= 1'b0;
      prev_capid_q   <= '0;
      rot_broken_q   <= 1'b0;
    end else if (consume_i) begin
      if (sample_i.last_sample) begin
        count_q        <= '0;
        first_code_q   <= '0;
        all_equal_q    <= 1'b1;
        halves_match_q <= 1'b1;
        soi_above_q    <= 1'b0;
        soi_bad_q      <= 1'b0;
        soi_reached_q  <= 1'b0;
        prev_capid_q   <= '0;
        rot_broken_q   <= 1'b0;
      end else begin
        count_q        <= count_d;
        first_code_q   <= first_code_d;
        all_equal_q    <= all_equal_d;
        halves_match_q <= halves_match_d;
        soi_above_q    <= soi_above_d;
        soi_bad_q      <= soi_bad_d;
        soi_reached_q  <= soi_reached_d;
        prev_capid_q   <= sample_i.capid;
        rot_broken_q   <= rot_broken_d;
      end
    end
  end

  // Codes of the first half of the frame; each entry is written before the
  // second half reads it.
  always_ff @(posedge clk_i) begin
    if (consume_i && in_first_half) begin
      half_mem[count_q[HALF_W-1:0]] <= sample_i.adc;
    end
  end

endmodule

`default_nettype wire

@@ sv/adcq_out_reg.sv @@
// ----------------------------------------------------------------------------
// adcq_out_reg
// Result register: holds one flag beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module adcq_out_reg
  import adcq_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_valid_i,
  input  wire result_t result_i,
  output logic         ready_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      result_o
);

  logic    valid_q, valid_d;
  result_t result_q;
  logic    load;

  assign ready_o = !valid_q || !out_stall_i;
  assign load    = load_valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (ready_o ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

@@ sv/adc_capid_frame_quality_flags.sv @@
// ----------------------------------------------------------------------------
// adc_capid_frame_quality_flags
// Frame quality flags for a stream of digitizer samples.
//
// Input channel: one sample per beat (ADC code, capacitor id, sample of
// interest index, bunch crossing, last-sample mark). Output channel: one beat
// per frame, issued for the last sample, with four flags and the frame length.
// Both channels use valid/stall; a beat moves when valid is high and stall is
// low.
// A sample is registered on entry and evaluated against the running frame
// state when it leaves the input register, which is when the result register
// is loaded. The result of a frame is presented from the result register.
// One sample is accepted every cycle while the result register is not held
// by a receiver stall.
// When the receiver stalls, the result holds; the input stalls only once both
// the input register and the result register are occupied.
// Reset clears the frame state, sets the thresholds and the expected phase to
// zero and empties both registers. Configuration writes take effect on the next
// sample evaluated; the write port has no read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_capid_frame_quality_flags
  import adcq_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [ADC_W-1:0]      adc_i,
  input  wire logic [CAP_W-1:0]      capid_i,
  input  wire logic [SOI_W-1:0]      soi_index_i,
  input  wire logic [BX_W-1:0]       bunch_crossing_i,
  input  wire logic                  last_sample_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       stuck_adc_o,
  output logic                       repeated_block_o,
  output logic                       bad_cap_phase_o,
  output logic                       cap_not_rotating_o,
  output logic [COUNT_W-1:0]         frame_length_o
);

  cfg_t    cfg_q;
  sample_t in_sample;
  sample_t s1_sample;
  logic    s1_valid;
  logic    out_ready;
  logic    consume;
  result_t eval_result;
  result_t out_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_STUCK_THRESHOLD:    cfg_q.stuck_threshold    <= cfg_wdata_i[ADC_W-1:0];
        REG_BLOCK_THRESHOLD:    cfg_q.block_threshold    <= cfg_wdata_i[ADC_W-1:0];
        REG_EXPECTED_CAP_PHASE: cfg_q.expected_cap_phase <= cfg_wdata_i[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_sample.adc            = adc_i;
    in_sample.capid          = capid_i;
    in_sample.soi_index      = soi_index_i;
    in_sample.bunch_crossing = bunch_crossing_i;
    in_sample.last_sample    = last_sample_i;
  end

  adcq_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_sample_i (in_sample),
    .advance_i   (out_ready),
    .s1_valid_o  (s1_valid),
    .s1_sample_o (s1_sample)
  );

  assign consume = s1_valid && out_ready;

  adcq_frame_eval u_frame_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .consume_i (consume),
    .sample_i  (s1_sample),
    .cfg_i     (cfg_q),
    .result_o  (eval_result)
  );

  adcq_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (consume && s1_sample.last_sample),
    .result_i     (eval_result),
    .ready_o      (out_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (out_result)
  );

  assign stuck_adc_o        = out_result.stuck_adc;
  assign repeated_block_o   = out_result.repeated_block;
  assign bad_cap_phase_o    = out_result.bad_cap_phase;
  assign cap_not_rotating_o = out_result.cap_not_rotating;
  assign frame_length_o     = out_result.frame_length;

endmodule

`default_nettype wire

@@ sv/adcq_port_checker.sv @@
// ----------------------------------------------------------------------------
// adcq_port_checker
// Port-level checks on the frame quality flagger, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module adcq_port_checker
  import adcq_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic               stuck_adc_o,
  input wire logic               repeated_block_o,
  input wire logic               cap_not_rotating_o,
  input wire logic [COUNT_W-1:0] frame_length_o
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_length_o != '0)
    else $error("empty frame reported");

  a_stuck_excludes_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(stuck_adc_o && repeated_block_o))
    else $error("stuck and repeated block flagged together");

  // A one-sample frame can be neither stuck nor out of rotation.
  a_single_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_length_o == COUNT_W'(1) |-> !stuck_adc_o && !cap_not_rotating_o)
    else $error("single-sample frame flagged");

  a_block_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && repeated_block_o |-> frame_length_o == COUNT_W'(BLOCK_LENGTH))
    else $error("repeated block on a frame of the wrong length");

endmodule

bind adc_capid_frame_quality_flags adcq_port_checker u_port_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .stuck_adc_o        (stuck_adc_o),
  .repeated_block_o   (repeated_block_o),
  .cap_not_rotating_o (cap_not_rotating_o),
  .frame_length_o     (frame_length_o)
);

`default_nettype wire
